FILE: rtl/vmph_pkg.sv
// Package for the VU meter peak hold unit: register codes, configuration and
// command structs, and fixed point helpers. No dependencies.
`default_nettype none

package vmph_pkg;

  localparam int unsigned BAND_INPUTS    = 6;
  localparam int unsigned BANDS_USED_DEF = 6;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 16;

  // Reciprocal multipliers. Each one is exact over the value range it sees.
  localparam logic [12:0] DIV100_MUL = 13'd5243;   // x/100, x < 43690
  localparam int unsigned DIV100_SH  = 19;
  localparam logic [15:0] DIV425_MUL = 16'd39477;  // x/425, x < 32961
  localparam int unsigned DIV425_SH  = 24;
  localparam logic [14:0] DIV61_MUL  = 15'd17190;  // x/61, x < 74898
  localparam int unsigned DIV61_SH   = 20;
  localparam logic [13:0] DIV72_MUL  = 14'd14564;  // x/72, x < 32768
  localparam int unsigned DIV72_SH   = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_BAR_MAX  = 3'd0,
    REG_RIGHT_BAR_MAX = 3'd1,
    REG_HOLD_MS       = 3'd2,
    REG_PULSE_GAP_MS  = 3'd3,
    REG_PULSE_MIN_LEN = 3'd4,
    REG_CLEAR_MS      = 3'd5,
    REG_FADE_MS       = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    FADE_NONE  = 2'd0,
    FADE_DIM   = 2'd1,
    FADE_CLEAR = 2'd2
  } fade_e;

  typedef struct packed {
    logic [6:0]  left_bar_max;
    logic [6:0]  right_bar_max;
    logic [15:0] hold_ms;
    logic [15:0] pulse_gap_ms;
    logic [6:0]  pulse_min_len;
    logic [15:0] clear_ms;
    logic [15:0] fade_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic band_en;
    logic len_en;
    logic peak_en;
    logic out_load;
  } cmd_t;

  // len*112/61 + 40, saturated at 255.
  function automatic logic [7:0] bright_of(input logic [6:0] len);
    logic [13:0] z;
    logic [28:0] p;
    logic [8:0]  b;
    z = 14'(len) * 14'd112;
    p = 29'(z) * 29'(DIV61_MUL);
    b = 9'(p[DIV61_SH +: 8]) + 9'd40;
    return (b > 9'd255) ? 8'd255 : b[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vu_meter_peak_hold_unit.sv
// Top level of the VU meter peak hold unit: configuration registers, the
// sequencer and the datapath. Depends on vmph_pkg, vmph_ctrl and vmph_dp.
//
//   channel  direction  handshake                    payload
//   input    in         in_valid_i / in_stall_o      channel, level_band0..5, now_ms
//   output   out        out_valid_o / out_stall_i    fade_mode .. pulse
//   config   in         cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One request at a time: it is accepted in the idle state, then the shared
// smoothing unit takes one band per cycle, followed by the length, peak and
// brightness states; brightness waits while the output register is held.
// A result waiting on out_stall_i does not block acceptance; only loading the
// next result waits for the output register to empty.
// Reset is asynchronous, active low, and sets all tracking state to zero.
`default_nettype none

module vu_meter_peak_hold_unit import vmph_pkg::*; #(
  parameter int unsigned BANDS_USED = BANDS_USED_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic                  channel_i,
  input  wire logic [7:0]            level_band0_i,
  input  wire logic [7:0]            level_band1_i,
  input  wire logic [7:0]            level_band2_i,
  input  wire logic [7:0]            level_band3_i,
  input  wire logic [7:0]            level_band4_i,
  input  wire logic [7:0]            level_band5_i,
  input  wire logic [31:0]           now_ms_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [1:0]            fade_mode_o,
  output      logic [6:0]            bar_length_o,
  output      logic [6:0]            peak_length_o,
  output      logic [7:0]            bar_bright_o,
  output      logic [7:0]            peak_bright_o,
  output      logic signed [7:0]     master_position_o,
  output      logic [7:0]            master_bright_o,
  output      logic                  pulse_o
);

  localparam int unsigned NBANDS = (BANDS_USED > BAND_INPUTS) ? BAND_INPUTS : BANDS_USED;
  localparam int unsigned BIDX_W = $clog2(NBANDS);

  cfg_t              cfg_q;
  cmd_t              cmd;
  logic [BIDX_W-1:0] band;
  logic [7:0]        lvl [BAND_INPUTS];

  assign lvl[0] = level_band0_i;
  assign lvl[1] = level_band1_i;
  assign lvl[2] = level_band2_i;
  assign lvl[3] = level_band3_i;
  assign lvl[4] = level_band4_i;
  assign lvl[5] = level_band5_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_bar_max  <= 7'd61;
      cfg_q.right_bar_max <= 7'd71;
      cfg_q.hold_ms       <= 16'd200;
      cfg_q.pulse_gap_ms  <= 16'd300;
      cfg_q.pulse_min_len <= 7'd30;
      cfg_q.clear_ms      <= 16'd40;
      cfg_q.fade_ms       <= 16'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT_BAR_MAX:  cfg_q.left_bar_max  <= cfg_wdata_i[6:0];
        REG_RIGHT_BAR_MAX: cfg_q.right_bar_max <= cfg_wdata_i[6:0];
        REG_HOLD_MS:       cfg_q.hold_ms       <= cfg_wdata_i;
        REG_PULSE_GAP_MS:  cfg_q.pulse_gap_ms  <= cfg_wdata_i;
        REG_PULSE_MIN_LEN: cfg_q.pulse_min_len <= cfg_wdata_i[6:0];
        REG_CLEAR_MS:      cfg_q.clear_ms      <= cfg_wdata_i;
        REG_FADE_MS:       cfg_q.fade_ms       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vmph_ctrl #(
    .NBANDS(NBANDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .band_o     (band)
  );

  vmph_dp #(
    .NBANDS(NBANDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .band_i           (band),
    .cfg_i            (cfg_q),
    .channel_i        (channel_i),
    .lvl_i            (lvl),
    .now_ms_i         (now_ms_i),
    .fade_mode_o      (fade_mode_o),
    .bar_length_o     (bar_length_o),
    .peak_length_o    (peak_length_o),
    .bar_bright_o     (bar_bright_o),
    .peak_bright_o    (peak_bright_o),
    .master_position_o(master_position_o),
    .master_bright_o  (master_bright_o),
    .pulse_o          (pulse_o)
  );

endmodule

`default_nettype wire

FILE: rtl/vmph_ctrl.sv
// Sequencer for the VU meter peak hold unit: steps one request through the
// band, length, peak and brightness phases. Depends on vmph_pkg.
`default_nettype none

module vmph_ctrl import vmph_pkg::*; #(
  parameter  int unsigned NBANDS = BANDS_USED_DEF,
  localparam int unsigned BIDX_W = $clog2(NBANDS)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      cmd_t              cmd_o,
  output      logic [BIDX_W-1:0] band_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAND,
    S_LEN,
    S_PEAK,
    S_BRIGHT
  } state_e;

  state_e            state_q;
  logic [BIDX_W-1:0] band_q;
  logic              out_valid_q;
  logic              band_last;
  logic              out_free;

  assign band_last = (band_q == BIDX_W'(NBANDS - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.band_en  = (state_q == S_BAND);
    cmd_o.len_en   = (state_q == S_LEN);
    cmd_o.peak_en  = (state_q == S_PEAK);
    cmd_o.out_load = (state_q == S_BRIGHT) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign band_o      = band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      band_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_BAND;
            band_q  <= '0;
          end
        end
        S_BAND: begin
          if (band_last) begin
            state_q <= S_LEN;
          end else begin
            band_q <= band_q + 1'b1;
          end
        end
        S_LEN:  state_q <= S_PEAK;
        S_PEAK: state_q <= S_BRIGHT;
        S_BRIGHT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // A new result replaces one that is being taken in the same cycle.
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(out_valid_q && out_stall_i))
    else $error("pending result overwritten");

  a_accept_starts_bands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_BAND && band_q == '0))
    else $error("accepted request did not start at band zero");

  a_bands_then_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BAND && band_last) |=> (state_q == S_LEN))
    else $error("band sweep did not end in the length phase");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded result not shown as valid");

endmodule

`default_nettype wire

FILE: rtl/vmph_dp.sv
// Datapath for the VU meter peak hold unit: band smoothing, bar scaling, peak
// hold and pulse tracking, brightness and output registers. Depends on vmph_pkg.
`default_nettype none

module vmph_dp import vmph_pkg::*; #(
  parameter  int unsigned NBANDS = BANDS_USED_DEF,
  localparam int unsigned BIDX_W = $clog2(NBANDS),
  localparam int unsigned SUM_W  = $clog2((NBANDS - 1) * 255 + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire logic [BIDX_W-1:0] band_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              channel_i,
  input  wire logic [7:0]        lvl_i [BAND_INPUTS],
  input  wire logic [31:0]       now_ms_i,
  output      logic [1:0]        fade_mode_o,
  output      logic [6:0]        bar_length_o,
  output      logic [6:0]        peak_length_o,
  output      logic [7:0]        bar_bright_o,
  output      logic [7:0]        peak_bright_o,
  output      logic signed [7:0] master_position_o,
  output      logic [7:0]        master_bright_o,
  output      logic              pulse_o
);

  // Tracking state.
  logic [7:0]  smooth_q [2][NBANDS];
  logic [6:0]  held_q   [2];
  logic [31:0] pkstamp_q[2];
  logic [31:0] pstamp_q [2];
  logic        phase_q;

  // Captured request and working registers.
  logic             ch_q;
  logic [7:0]       lvl_q [NBANDS];
  logic [31:0]      now_q;
  logic [7:0]       s0_q;
  logic [SUM_W-1:0] sum_q;
  logic [14:0]      prod_q;
  logic [6:0]       pos1_q;
  logic [6:0]       len_q;
  logic [6:0]       peak_q;
  logic             pulse_q;
  fade_e            fade_q;
  logic [7:0]       mpos_q;
  logic [7:0]       mbright_q;

  // Band smoothing: (92*s + 8*l) / 100.
  logic [7:0]  s_cur;
  logic [7:0]  l_cur;
  logic [14:0] mix;
  logic [27:0] mix_p;
  logic [7:0]  s_new;

  assign s_cur = smooth_q[ch_q][band_i];
  assign l_cur = lvl_q[band_i];
  assign mix   = 15'(s_cur) * 15'd92 + 15'(l_cur) * 15'd8;
  assign mix_p = 28'(mix) * 28'(DIV100_MUL);
  assign s_new = mix_p[DIV100_SH +: 8];

  // Bar length and master position.
  logic [6:0]  bar_max;
  logic [15:0] pos_y;
  logic [31:0] pos_p;

  assign bar_max = ch_q ? cfg_i.right_bar_max : cfg_i.left_bar_max;
  assign pos_y   = 16'(sum_q) * 16'd24;
  assign pos_p   = 32'(pos_y) * 32'(DIV425_MUL);

  // prod/255 by a reciprocal estimate that is at most one low.
  logic [23:0] len_a;
  logic [6:0]  len_q0;
  logic [14:0] len_r;
  logic [6:0]  len;

  assign len_a  = 24'(prod_q) * 24'd257;
  assign len_q0 = len_a[16 +: 7];
  assign len_r  = prod_q - 15'(len_q0) * 15'd255;
  assign len    = (len_r >= 15'd255) ? len_q0 + 7'd1 : len_q0;

  // Peak hold, pulse and fade.
  logic [6:0]  held_cur;
  logic        rise;
  logic        pulse;
  logic [6:0]  peak;
  logic        phase_nxt;
  logic        decay;
  logic [31:0] d_pulse;
  logic [31:0] d_peak;
  logic [31:0] d0;
  logic [31:0] d1;
  fade_e       fade;

  assign held_cur  = held_q[ch_q];
  assign d_pulse   = now_q - pstamp_q[ch_q];
  assign d_peak    = now_q - pkstamp_q[ch_q];
  assign rise      = len > held_cur;
  assign pulse     = rise && (d_pulse > 32'(cfg_i.pulse_gap_ms)) && (len > cfg_i.pulse_min_len);
  assign peak      = rise ? len : held_cur;
  assign phase_nxt = phase_q ^ !ch_q;
  // When the peak rises this frame its stamp is now, so it cannot decay yet.
  assign decay     = !phase_nxt && !rise && (held_cur != 7'd0)
                     && (d_peak > 32'(cfg_i.hold_ms));
  assign d0        = now_q - pstamp_q[0];
  assign d1        = now_q - pstamp_q[1];

  always_comb begin
    fade = FADE_NONE;
    if (!ch_q) begin
      if (d0 > 32'(cfg_i.clear_ms) && d1 > 32'(cfg_i.clear_ms)) begin
        fade = FADE_CLEAR;
      end else if (d0 > 32'(cfg_i.fade_ms) && d1 > 32'(cfg_i.fade_ms)) begin
        fade = FADE_DIM;
      end
    end
  end

  // Master brightness: pos1*255/72.
  logic [14:0] mb_z;
  logic [28:0] mb_p;

  assign mb_z = 15'(pos1_q) * 15'd255;
  assign mb_p = 29'(mb_z) * 29'(DIV72_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        for (int b = 0; b < NBANDS; b++) begin
          smooth_q[c][b] <= '0;
        end
        held_q[c]    <= '0;
        pkstamp_q[c] <= '0;
        pstamp_q[c]  <= '0;
      end
      phase_q <= 1'b0;
    end else begin
      if (cmd_i.band_en) begin
        smooth_q[ch_q][band_i] <= s_new;
      end
      if (cmd_i.peak_en) begin
        phase_q      <= phase_nxt;
        held_q[ch_q] <= peak - 7'(decay);
        if (rise) begin
          pkstamp_q[ch_q] <= now_q;
        end
        if (pulse) begin
          pstamp_q[ch_q] <= now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_i;
      now_q <= now_ms_i;
      for (int b = 0; b < NBANDS; b++) begin
        lvl_q[b] <= lvl_i[b];
      end
      sum_q <= '0;
    end
    if (cmd_i.band_en) begin
      if (band_i == '0) begin
        s0_q <= s_new;
      end else begin
        sum_q <= sum_q + SUM_W'(s_new);
      end
    end
    if (cmd_i.len_en) begin
      prod_q <= 15'(s0_q) * 15'(bar_max);
      pos1_q <= pos_p[DIV425_SH +: 7];
    end
    if (cmd_i.peak_en) begin
      len_q     <= len;
      peak_q    <= peak;
      pulse_q   <= pulse;
      fade_q    <= fade;
      mpos_q    <= 8'(pos1_q) - 8'd1;
      mbright_q <= mb_p[DIV72_SH +: 8];
    end
    if (cmd_i.out_load) begin
      fade_mode_o       <= fade_q;
      bar_length_o      <= len_q;
      peak_length_o     <= peak_q;
      bar_bright_o      <= bright_of(len_q);
      peak_bright_o     <= bright_of(peak_q);
      master_position_o <= mpos_q;
      master_bright_o   <= mbright_q;
      pulse_o           <= pulse_q;
    end
  end

endmodule

`default_nettype wire

FILE: tb/vmph_checker.sv
// Checker for the VU meter peak hold unit: mirrors the register file, predicts
// every meter result from the accepted requests and compares it field by field.
// Depends on vmph_pkg.
`default_nettype none

module vmph_checker import vmph_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic                  channel_i,
  input  wire logic [7:0]            level_band0_i,
  input  wire logic [7:0]            level_band1_i,
  input  wire logic [7:0]            level_band2_i,
  input  wire logic [7:0]            level_band3_i,
  input  wire logic [7:0]            level_band4_i,
  input  wire logic [7:0]            level_band5_i,
  input  wire logic [31:0]           now_ms_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [1:0]            fade_mode_i,
  input  wire logic [6:0]            bar_length_i,
  input  wire logic [6:0]            peak_length_i,
  input  wire logic [7:0]            bar_bright_i,
  input  wire logic [7:0]            peak_bright_i,
  input  wire logic signed [7:0]     master_position_i,
  input  wire logic [7:0]            master_bright_i,
  input  wire logic                  pulse_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);

  localparam int unsigned NBANDS  = (BANDS_USED_DEF > BAND_INPUTS) ? BAND_INPUTS : BANDS_USED_DEF;
  localparam int unsigned SUM_TOP = (NBANDS - 1 > 5) ? 5 : NBANDS - 1;
  localparam int          MAX_REPORTS = 40;

  typedef struct packed {
    fade_e              fade;
    logic [6:0]         bar_len;
    logic [6:0]         peak_len;
    logic [7:0]         bar_bright;
    logic [7:0]         peak_bright;
    logic signed [7:0]  master_pos;
    logic [7:0]         master_bright;
    logic               pulse;
  } meter_result_t;

  meter_result_t expected_meter_q[$];

  cfg_t        cfg;
  logic [7:0]  smoothed_level[2][BAND_INPUTS];
  logic [6:0]  held_peak[2];
  logic [31:0] peak_stamp[2];
  logic [31:0] pulse_stamp[2];
  logic        decay_phase;
  int          mismatch_total;
  int          results_seen;

  function automatic logic [7:0] bright_level(input int unsigned len);
    int unsigned v;
    v = len * 112 / 61 + 40;
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_total++;
    if (mismatch_total <= MAX_REPORTS)
      $display("meter result %0d: %s is %0d, predicted %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : meter_model
    logic          ch;
    logic [31:0]   now;
    logic [47:0]   levels;
    int unsigned   d0, d1, acc, bar_max, len, sum, pos1;
    meter_result_t want, got;
    if (!rst_ni) begin
      cfg.left_bar_max  = 7'd61;
      cfg.right_bar_max = 7'd71;
      cfg.hold_ms       = 16'd200;
      cfg.pulse_gap_ms  = 16'd300;
      cfg.pulse_min_len = 7'd30;
      cfg.clear_ms      = 16'd40;
      cfg.fade_ms       = 16'd30;
      for (int c = 0; c < 2; c++) begin
        for (int b = 0; b < BAND_INPUTS; b++) smoothed_level[c][b] = '0;
        held_peak[c]   = '0;
        peak_stamp[c]  = '0;
        pulse_stamp[c] = '0;
      end
      decay_phase    = 1'b0;
      mismatch_total = 0;
      results_seen   = 0;
      expected_meter_q.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_we_i) begin
        // Narrow registers keep only their low bits.
        case (cfg_idx_i)
          REG_LEFT_BAR_MAX:  cfg.left_bar_max  = cfg_wdata_i[6:0];
          REG_RIGHT_BAR_MAX: cfg.right_bar_max = cfg_wdata_i[6:0];
          REG_HOLD_MS:       cfg.hold_ms       = cfg_wdata_i;
          REG_PULSE_GAP_MS:  cfg.pulse_gap_ms  = cfg_wdata_i;
          REG_PULSE_MIN_LEN: cfg.pulse_min_len = cfg_wdata_i[6:0];
          REG_CLEAR_MS:      cfg.clear_ms      = cfg_wdata_i;
          REG_FADE_MS:       cfg.fade_ms       = cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        ch     = channel_i;
        now    = now_ms_i;
        levels = {level_band5_i, level_band4_i, level_band3_i,
                  level_band2_i, level_band1_i, level_band0_i};
        want       = '0;
        want.fade  = FADE_NONE;
        if (!ch) begin
          d0 = now - pulse_stamp[0];
          d1 = now - pulse_stamp[1];
          if (d0 > cfg.clear_ms && d1 > cfg.clear_ms) want.fade = FADE_CLEAR;
          else if (d0 > cfg.fade_ms && d1 > cfg.fade_ms) want.fade = FADE_DIM;
          decay_phase = ~decay_phase;
        end
        for (int b = 0; b < NBANDS; b++) begin
          acc = 92 * smoothed_level[ch][b] + 8 * levels[8*b +: 8];
          smoothed_level[ch][b] = 8'(acc / 100);
        end
        bar_max = ch ? cfg.right_bar_max : cfg.left_bar_max;
        len     = smoothed_level[ch][0] * bar_max / 255;
        if (len > held_peak[ch]) begin
          if ((now - pulse_stamp[ch]) > cfg.pulse_gap_ms && len > cfg.pulse_min_len) begin
            pulse_stamp[ch] = now;
            want.pulse      = 1'b1;
          end
          held_peak[ch]  = 7'(len);
          peak_stamp[ch] = now;
        end
        want.peak_len = held_peak[ch];
        // The reported peak is taken before this frame's decay step.
        if (!decay_phase && held_peak[ch] != '0 && (now - peak_stamp[ch]) > cfg.hold_ms)
          held_peak[ch] = held_peak[ch] - 7'd1;
        sum = 0;
        for (int b = 1; b <= SUM_TOP; b++) sum += smoothed_level[ch][b];
        pos1 = sum * 72 / 1275;
        want.bar_len       = 7'(len);
        want.bar_bright    = bright_level(len);
        want.peak_bright   = bright_level(want.peak_len);
        want.master_pos    = 8'(pos1 - 1);
        want.master_bright = 8'(pos1 * 255 / 72);
        expected_meter_q.push_back(want);
      end

      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (expected_meter_q.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          got = expected_meter_q.pop_front();
          if (fade_mode_i != got.fade)
            report_mismatch("fade_mode", int'(fade_mode_i), int'(got.fade));
          if (bar_length_i != got.bar_len)
            report_mismatch("bar_length", int'(bar_length_i), int'(got.bar_len));
          if (peak_length_i != got.peak_len)
            report_mismatch("peak_length", int'(peak_length_i), int'(got.peak_len));
          if (bar_bright_i != got.bar_bright)
            report_mismatch("bar_bright", int'(bar_bright_i), int'(got.bar_bright));
          if (peak_bright_i != got.peak_bright)
            report_mismatch("peak_bright", int'(peak_bright_i), int'(got.peak_bright));
          if (master_position_i != got.master_pos)
            report_mismatch("master_position", int'(master_position_i), int'(got.master_pos));
          if (master_bright_i != got.master_bright)
            report_mismatch("master_bright", int'(master_bright_i), int'(got.master_bright));
          if (pulse_i != got.pulse)
            report_mismatch("pulse", int'(pulse_i), int'(got.pulse));
        end
      end

      mismatch_count_o <= mismatch_total;
      pending_o        <= expected_meter_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Top of the VU meter peak hold testbench: clock, reset, register settings,
// frame stimulus and output back-pressure, with the verdict at the end.
// Depends on vmph_pkg, vu_meter_peak_hold_unit and vmph_checker.
`default_nettype none

module testbench import vmph_pkg::*;;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_PAD     = 20;
  localparam int PHASES        = 7;
  localparam int PHASE_STEPS   = 42;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  channel     = 1'b0;
  logic [47:0]           band_levels = '0;
  logic [31:0]           now_ms      = '0;
  logic                  out_stall   = 1'b0;
  bit                    quiet_sender = 1'b0;

  wire logic                   in_stall;
  wire logic                   out_valid;
  wire logic [1:0]             fade_mode;
  wire logic [6:0]             bar_length;
  wire logic [6:0]             peak_length;
  wire logic [7:0]             bar_bright;
  wire logic [7:0]             peak_bright;
  wire logic signed [7:0]      master_position;
  wire logic [7:0]             master_bright;
  wire logic                   pulse;
  int                          mismatch_count;
  int                          pending;
  int                          cycle_count = 0;

  vu_meter_peak_hold_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .channel_i         (channel),
    .level_band0_i     (band_levels[7:0]),
    .level_band1_i     (band_levels[15:8]),
    .level_band2_i     (band_levels[23:16]),
    .level_band3_i     (band_levels[31:24]),
    .level_band4_i     (band_levels[39:32]),
    .level_band5_i     (band_levels[47:40]),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .fade_mode_o       (fade_mode),
    .bar_length_o      (bar_length),
    .peak_length_o     (peak_length),
    .bar_bright_o      (bar_bright),
    .peak_bright_o     (peak_bright),
    .master_position_o (master_position),
    .master_bright_o   (master_bright),
    .pulse_o           (pulse)
  );

  vmph_checker u_meter_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .channel_i         (channel),
    .level_band0_i     (band_levels[7:0]),
    .level_band1_i     (band_levels[15:8]),
    .level_band2_i     (band_levels[23:16]),
    .level_band3_i     (band_levels[31:24]),
    .level_band4_i     (band_levels[39:32]),
    .level_band5_i     (band_levels[47:40]),
    .now_ms_i          (now_ms),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .fade_mode_i       (fade_mode),
    .bar_length_i      (bar_length),
    .peak_length_i     (peak_length),
    .bar_bright_i      (bar_bright),
    .peak_bright_i     (peak_bright),
    .master_position_i (master_position),
    .master_bright_i   (master_bright),
    .pulse_i           (pulse),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output back-pressure: mostly short stalls, now and then a long one, and
  // occasional long stretches with no stall at all.
  initial begin : result_backpressure
    int free_len, stall_len;
    @(posedge clk_i);
    forever begin
      free_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
      stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk_i);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  function automatic int request_gap();
    int r;
    r = $urandom_range(0, 19);
    if (quiet_sender || r < 9) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and returns at the edge where it is taken.
  task automatic send_request(input logic ch, input logic [47:0] levels,
                              input logic [31:0] stamp);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    channel     <= ch;
    band_levels <= levels;
    now_ms      <= stamp;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Levels of one channel for one frame: bass follows the beat, the upper
  // bands follow the loudness mode of the moment.
  function automatic logic [47:0] frame_levels(input bit burst, input int loudness);
    logic [47:0] lv;
    lv[7:0] = burst ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 60));
    for (int b = 1; b < 6; b++) begin
      case (loudness)
        0:       lv[8*b +: 8] = 8'($urandom_range(0, 40));
        1:       lv[8*b +: 8] = 8'($urandom_range(0, 255));
        2:       lv[8*b +: 8] = 8'($urandom_range(200, 255));
        default: lv[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
    end
    return lv;
  endfunction

  initial begin : stimulus
    logic [15:0] setting[7];
    logic [31:0] stamp;
    logic [47:0] lv;
    int          burst_left, loudness, step_kind;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset settings: silence at time zero, a full
    // scale run that builds a peak and a pulse, bit patterns, the clock
    // wrapping past zero, and a lone right channel request.
    for (int f = 0; f < 12; f++) begin
      lv = (f < 2) ? 48'h0 : (f < 9) ? 48'hFFFF_FFFF_FFFF :
           (f % 2 != 0) ? 48'hAAAA_AAAA_AAAA : 48'h5555_5555_5555;
      stamp = (f < 10) ? 32'(f * 50) : (f == 10) ? 32'hFFFF_FFE0 : 32'h0000_0020;
      send_request(1'b0, lv, stamp);
      send_request(1'b1, lv, stamp);
    end
    send_request(1'b1, 48'hFFFF_FFFF_FFFF, 32'h0000_0400);
    wait_idle();

    for (int phase = 0; phase < PHASES; phase++) begin
      // Order: left max, right max, hold, pulse gap, pulse min, clear, fade.
      case (phase)
        0: setting = '{16'd61, 16'd71, 16'd200, 16'd300, 16'd30, 16'd40, 16'd30};
        1: setting = '{16'd127, 16'd127, 16'hFFFF, 16'hFFFF, 16'd127, 16'hFFFF, 16'hFFFF};
        2: setting = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        // Upper bits above a narrow register are dropped, so left max reads 0.
        3: setting = '{16'hFF80, 16'd127, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0};
        4: setting = '{16'd100, 16'd50, 16'd100, 16'd150, 16'd20, 16'd500, 16'd100};
        5: for (int i = 0; i < 7; i++) setting[i] = 16'($urandom_range(0, 65535));
        default: begin
          setting[0] = 16'($urandom_range(0, 65535));
          setting[1] = 16'($urandom_range(0, 65535));
          setting[2] = 16'($urandom_range(0, 400));
          setting[3] = 16'($urandom_range(0, 600));
          setting[4] = 16'($urandom_range(0, 60));
          setting[5] = 16'($urandom_range(0, 300));
          setting[6] = 16'($urandom_range(0, 300));
        end
      endcase
      write_reg(REG_LEFT_BAR_MAX,  setting[0]);
      write_reg(REG_RIGHT_BAR_MAX, setting[1]);
      write_reg(REG_HOLD_MS,       setting[2]);
      write_reg(REG_PULSE_GAP_MS,  setting[3]);
      write_reg(REG_PULSE_MIN_LEN, setting[4]);
      write_reg(REG_CLEAR_MS,      setting[5]);
      write_reg(REG_FADE_MS,       setting[6]);
      if (phase == 5) write_reg(CFG_IDX_SPARE, 16'($urandom_range(0, 65535)));
      cfg_we <= 1'b0;
      @(posedge clk_i);

      quiet_sender = ($urandom_range(0, 3) == 0);
      stamp = $urandom();
      if ($urandom_range(0, 2) == 0) stamp = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
      burst_left = 0;
      loudness   = $urandom_range(0, 3);

      for (int s = 0; s < PHASE_STEPS; s++) begin
        step_kind = $urandom_range(0, 99);
        if (step_kind < 2) stamp = $urandom();
        else if (step_kind < 7) stamp = stamp + 32'($urandom_range(200, 3000));
        else stamp = stamp + 32'($urandom_range(5, 60));
        if ($urandom_range(0, 11) == 0) loudness = $urandom_range(0, 3);
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(2, 8);

        if ($urandom_range(0, 9) == 0) begin
          // Noise: a lone request with any channel, levels and time stamp.
          lv = {16'($urandom()), $urandom()};
          send_request(1'($urandom_range(0, 1)), lv,
                       $urandom_range(0, 1) ? stamp : $urandom());
        end else begin
          send_request(1'b0, frame_levels(burst_left > 0, loudness), stamp);
          send_request(1'b1, frame_levels(burst_left > 0, loudness),
                       stamp + 32'($urandom_range(0, 2)));
        end
      end
      wait_idle();
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/vmph_pkg.sv
rtl/vmph_ctrl.sv
rtl/vmph_dp.sv
rtl/vu_meter_peak_hold_unit.sv
tb/vmph_checker.sv
tb/testbench.sv
